>>> src/bdac_pkg.sv
`timescale 1ns / 1ps

package bdac_pkg;

   // Fixed field widths.
   localparam int VALUE_W   = 64;
   localparam int CHAR_W    = 6;
   localparam int COUNT_W   = 5;
   localparam int DIGIT_W   = 4;

   // A 64-bit value needs at most twenty decimal digits.
   localparam int DIGIT_SLOTS        = 20;
   localparam int DEFAULT_MAX_DIGITS = 20;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

   // Double-dabble correction: a BCD digit of five or more gets three added
   // before the shift, so that the shift carries correctly into the next digit.
   function automatic logic [DIGIT_W-1:0] add3 (input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] r;
      if (d >= 4'd5) begin
         r = d + 4'd3;
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

>>> src/bdac_front.sv
`timescale 1ns / 1ps

module bdac_front
   import bdac_pkg::*;
#(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
   parameter int ENTRY_W    = MAX_DIGITS * DIGIT_W + COUNT_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   output logic               push_valid,
   input  logic               push_ready,
   output logic [ENTRY_W-1:0] push_data
);

   localparam int BCD_W = MAX_DIGITS * DIGIT_W;
   localparam int CNT_W = $clog2(VALUE_W);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_W - 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_PUSH  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [VALUE_W-1:0] shreg_ff, shreg_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic               sticky_ff, sticky_in;

   logic [BCD_W-1:0]   corrected;
   logic [COUNT_W-1:0] used;

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         corrected[i*DIGIT_W +: DIGIT_W] = add3(bcd_ff[i*DIGIT_W +: DIGIT_W]);
      end
   end

   // Digit count: position of the highest non-zero digit, at least one, and the
   // full width when digits were carried out beyond the top.
   always_comb begin
      used = COUNT_W'(1);
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] != '0) begin
            used = COUNT_W'(i + 1);
         end
      end
      if (sticky_ff) begin
         used = COUNT_W'(MAX_DIGITS);
      end
   end

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      shreg_in   = shreg_ff;
      bcd_in     = bcd_ff;
      sticky_in  = sticky_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               shreg_in   = req_value;
               bcd_in     = '0;
               sticky_in  = 1'b0;
               bit_cnt_in = '0;
               state_in   = S_SHIFT;
            end
         end
         S_SHIFT: begin
            bcd_in     = {corrected[BCD_W-2:0], shreg_ff[VALUE_W-1]};
            sticky_in  = sticky_ff | corrected[BCD_W-1];
            shreg_in   = {shreg_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + CNT_W'(1);
            if (bit_cnt_ff == LAST_BIT) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bit_cnt_ff <= bit_cnt_in;
      shreg_ff   <= shreg_in;
      bcd_ff     <= bcd_in;
      sticky_ff  <= sticky_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign push_valid = (state_ff == S_PUSH);
   assign push_data  = {used, bcd_ff};

`ifndef NO_ASSERTIONS
   a_shift_runs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && bit_cnt_ff != LAST_BIT) |=> state_ff == S_SHIFT)
      else $error("conversion left the shift phase early");
`endif

endmodule

>>> src/bdac_fifo.sv
`timescale 1ns / 1ps

module bdac_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   // Two-entry queue between the converter and the digit emitter.
   localparam logic [1:0] DEPTH = 2'd2;

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign in_ready  = (cnt_ff != DEPTH);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_push   = in_valid & in_ready;
   assign do_pop    = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH)
      else $error("queue fill count beyond its depth");
`endif

endmodule

>>> src/bdac_back.sv
`timescale 1ns / 1ps

module bdac_back
   import bdac_pkg::*;
#(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
   parameter int ENTRY_W    = MAX_DIGITS * DIGIT_W + COUNT_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  logic [ENTRY_W-1:0] pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_digit_char,
   output logic [COUNT_W-1:0] rsp_digit_count,
   output logic               rsp_last
);

   localparam int BCD_W = MAX_DIGITS * DIGIT_W;
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic               valid_ff, valid_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;

   logic [COUNT_W-1:0] pop_count;
   logic [COUNT_W-1:0] pop_top;
   logic               rsp_taken;
   logic [DIGIT_W-1:0] digit;

   assign pop_count = pop_data[ENTRY_W-1 -: COUNT_W];
   assign pop_top   = pop_count - COUNT_W'(1);
   assign rsp_taken = valid_ff & rsp_ready;
   assign pop_ready = ~valid_ff | (rsp_ready & rsp_last);

   always_comb begin
      valid_in = valid_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      if (pop_ready && pop_valid) begin
         valid_in = 1'b1;
         bcd_in   = pop_data[BCD_W-1:0];
         count_in = pop_count;
         pos_in   = pop_top[IDX_W-1:0];
      end else if (rsp_taken) begin
         if (rsp_last) begin
            valid_in = 1'b0;
         end else begin
            pos_in = pos_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      pos_ff   <= pos_in;
   end

   assign digit           = bcd_ff[pos_ff*DIGIT_W +: DIGIT_W];
   assign rsp_valid       = valid_ff;
   assign rsp_digit_char  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
   assign rsp_digit_count = count_ff;
   assign rsp_last        = (pos_ff == '0);

`ifndef NO_ASSERTIONS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (COUNT_W'(pos_ff) < count_ff))
      else $error("digit position beyond the digit count");
   a_word_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_taken && !rsp_last) |=> (valid_ff && $stable(count_ff)))
      else $error("digit string broken off before its last digit");
`endif

endmodule

>>> src/binary_to_decimal_ascii.sv
// Converts a 64-bit unsigned value to decimal ASCII digits, most significant first.
// Throughput: one value per conversion, set by the 64-step bit-serial double-dabble shifter
// in the front end, which takes no new value until the last one is pushed into the queue;
// or one digit word per cycle, while rsp_ready stays high, when the output side is slower.
// Reset is synchronous and active high; it empties the queue and idles both ends.
`timescale 1ns / 1ps

module binary_to_decimal_ascii
   import bdac_pkg::*;
#(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_digit_char,
   output logic [COUNT_W-1:0] rsp_digit_count,
   output logic               rsp_last
);

   // One queue entry holds the packed BCD digits of a value and its digit count.
   localparam int ENTRY_W = MAX_DIGITS * DIGIT_W + COUNT_W;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;

   // The front end takes a value word and runs it through the double-dabble
   // shifter, then works out how many digits the text needs.
   bdac_front #(
      .MAX_DIGITS (MAX_DIGITS),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // The queue lets the next conversion run while digits of the previous value
   // are still waiting to be taken.
   bdac_fifo #(
      .WIDTH (ENTRY_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // The back end emits one digit word per handshake, from the top digit down.
   bdac_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .ENTRY_W    (ENTRY_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_digit_count (rsp_digit_count),
      .rsp_last        (rsp_last)
   );

endmodule
